/* src/hsl_to_rgb_converter_top_assert.svh */
// assertion macros for the bound checker in hsl2rgb_checker.sv
`ifndef HSL_TO_RGB_CONVERTER_TOP_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_TOP_ASSERT_SVH

// same-cycle implication
`define HSL_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hsl to rgb assertion failed");

// next-cycle implication
`define HSL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hsl to rgb assertion failed");

`endif

/* src/hsl2rgb_pkg.sv */
`default_nettype none

package hsl2rgb_pkg;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

/* src/hsl2rgb_front.sv */
`default_nettype none

module hsl2rgb_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [FRAC_BITS-1:0]            in_hue,
   input  logic [FRAC_BITS:0]              in_saturation,
   input  logic [FRAC_BITS:0]              in_lightness,
   input  hsl2rgb_pkg::queue_status_type   queue_status,
   output logic                            push,
   output logic [5*FRAC_BITS+1:0]          push_data
);

   localparam int F = FRAC_BITS;
   localparam logic [F:0]   ONE   = {1'b1, {F{1'b0}}};
   localparam logic [F-1:0] THIRD = F'((1 << FRAC_BITS) / 3);

   logic         f0_valid_ff, f0_valid_in;
   logic [F-1:0] f0_hue_ff;
   logic [F:0]   f0_sat_ff, f0_light_ff;
   logic         f1_valid_ff, f1_valid_in;
   logic [F-1:0] f1_hue_ff;
   logic [F:0]   f1_sat_ff, f1_light_ff, f1_ls_ff;
   logic         f0_ready, f1_ready;

   logic [F:0]     sat_cl, light_cl;
   logic [2*F+1:0] ls_prod;
   logic [F+1:0]   q_raw, light2, p_raw;
   logic [F:0]     q_val, p_val;
   logic [F-1:0]   ph_red, ph_green, ph_blue;

   assign f1_ready = !f1_valid_ff || !queue_status.full;
   assign f0_ready = !f0_valid_ff || f1_ready;
   assign in_ready = f0_ready;
   assign push     = f1_valid_ff && !queue_status.full;

   // clamp and l*s
   always_comb begin
      sat_cl   = (f0_sat_ff > ONE) ? ONE : f0_sat_ff;
      light_cl = (f0_light_ff > ONE) ? ONE : f0_light_ff;
      ls_prod  = (2*F+2)'(sat_cl) * (2*F+2)'(light_cl);
   end

   // q, p and the channel phases
   always_comb begin
      if (f1_light_ff[F:F-1] == 2'b00) begin
         q_raw = {1'b0, f1_light_ff} + {1'b0, f1_ls_ff};
      end else begin
         q_raw = {1'b0, f1_light_ff} + {1'b0, f1_sat_ff} - {1'b0, f1_ls_ff};
      end
      q_val  = (q_raw > {1'b0, ONE}) ? ONE : q_raw[F:0];
      light2 = {f1_light_ff, 1'b0};
      p_raw  = (light2 >= {1'b0, q_val}) ? light2 - {1'b0, q_val} : '0;
      p_val  = (p_raw > {1'b0, q_val}) ? q_val : p_raw[F:0];
      ph_red   = f1_hue_ff + THIRD;
      ph_green = f1_hue_ff;
      ph_blue  = f1_hue_ff - THIRD;
   end

   assign push_data = {q_val, p_val, ph_blue, ph_green, ph_red};

   always_comb begin
      f0_valid_in = f0_valid_ff;
      if (f0_ready) begin
         f0_valid_in = in_valid;
      end
      f1_valid_in = f1_valid_ff;
      if (f1_ready) begin
         f1_valid_in = f0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_valid_ff <= 1'b0;
         f1_valid_ff <= 1'b0;
      end else begin
         f0_valid_ff <= f0_valid_in;
         f1_valid_ff <= f1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (f0_ready && in_valid) begin
         f0_hue_ff   <= in_hue;
         f0_sat_ff   <= in_saturation;
         f0_light_ff <= in_lightness;
      end
      if (f1_ready && f0_valid_ff) begin
         f1_hue_ff   <= f0_hue_ff;
         f1_sat_ff   <= sat_cl;
         f1_light_ff <= light_cl;
         f1_ls_ff    <= ls_prod[2*F:F];
      end
   end

endmodule

`default_nettype wire

/* src/hsl2rgb_queue.sv */
`default_nettype none

module hsl2rgb_queue #(
   parameter int WIDTH = 82
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [WIDTH-1:0]              push_data,
   input  logic                          pop,
   output logic [WIDTH-1:0]              head_data,
   output hsl2rgb_pkg::queue_status_type status
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   logic [DEPTH-1:0][WIDTH-1:0] mem_ff;
   logic [PTR_W-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]              count_ff, count_in;

   assign status.full  = (count_ff == (PTR_W+1)'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_data    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* src/hsl2rgb_back.sv */
`default_nettype none

module hsl2rgb_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  hsl2rgb_pkg::queue_status_type queue_status,
   input  logic [5*FRAC_BITS+1:0]        head_data,
   output logic                          pop,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [2:0][FRAC_BITS:0]       out_rgb
);

   localparam int F = FRAC_BITS;
   localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

   localparam logic [1:0] SEG_RISE = 2'd0;
   localparam logic [1:0] SEG_HIGH = 2'd1;
   localparam logic [1:0] SEG_FALL = 2'd2;
   localparam logic [1:0] SEG_LOW  = 2'd3;

   logic [2:0][F-1:0] phase;
   logic [F:0]        head_p, head_q;

   logic [2:0][F+2:0] t6;
   logic [2:0][F+1:0] t3;
   logic [2:0][1:0]   seg_in;
   logic [2:0][F:0]   mul_in;

   logic              b1_valid_ff, b1_valid_in;
   logic [F:0]        b1_p_ff, b1_q_ff, b1_d_ff;
   logic [2:0][1:0]   b1_seg_ff;
   logic [2:0][F:0]   b1_mul_ff;

   logic              b2_valid_ff, b2_valid_in;
   logic [F:0]        b2_p_ff, b2_q_ff;
   logic [2:0][1:0]   b2_seg_ff;
   logic [2:0][2*F+1:0] b2_prod_ff;

   logic              out_valid_ff, out_valid_in;
   logic [2:0][F:0]   out_rgb_ff, rgb_in;

   logic              b1_ready, b2_ready, o_ready;

   assign phase[0] = head_data[F-1:0];
   assign phase[1] = head_data[2*F-1:F];
   assign phase[2] = head_data[3*F-1:2*F];
   assign head_p   = head_data[4*F:3*F];
   assign head_q   = head_data[5*F+1:4*F+1];

   assign o_ready  = !out_valid_ff || out_ready;
   assign b2_ready = !b2_valid_ff || o_ready;
   assign b1_ready = !b1_valid_ff || b2_ready;
   assign pop      = !queue_status.empty && b1_ready;

   // pick the segment of the ramp and its multiplier
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         t6[c] = (F+3)'({phase[c], 2'b00}) + (F+3)'({phase[c], 1'b0});
         t3[c] = (F+2)'({phase[c], 1'b0}) + (F+2)'(phase[c]);
         if (t6[c] < (F+3)'(ONE)) begin
            seg_in[c] = SEG_RISE;
            mul_in[c] = t6[c][F:0];
         end else if (!phase[c][F-1]) begin
            seg_in[c] = SEG_HIGH;
            mul_in[c] = '0;
         end else if (t3[c] < {ONE, 1'b0}) begin
            seg_in[c] = SEG_FALL;
            mul_in[c] = (F+1)'((F+3)'({ONE, 2'b00}) - t6[c]);
         end else begin
            seg_in[c] = SEG_LOW;
            mul_in[c] = '0;
         end
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         unique case (b2_seg_ff[c]) inside
            SEG_RISE, SEG_FALL: rgb_in[c] = b2_p_ff + b2_prod_ff[c][2*F:F];
            SEG_HIGH:           rgb_in[c] = b2_q_ff;
            default:            rgb_in[c] = b2_p_ff;
         endcase
      end
   end

   always_comb begin
      b1_valid_in  = b1_ready ? !queue_status.empty : b1_valid_ff;
      b2_valid_in  = b2_ready ? b1_valid_ff : b2_valid_ff;
      out_valid_in = o_ready ? b2_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff  <= b1_valid_in;
         b2_valid_ff  <= b2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         b1_p_ff   <= head_p;
         b1_q_ff   <= head_q;
         b1_d_ff   <= head_q - head_p;
         b1_seg_ff <= seg_in;
         b1_mul_ff <= mul_in;
      end
      if (b2_ready && b1_valid_ff) begin
         b2_p_ff   <= b1_p_ff;
         b2_q_ff   <= b1_q_ff;
         b2_seg_ff <= b1_seg_ff;
         for (int c = 0; c < 3; c++) begin
            b2_prod_ff[c] <= (2*F+2)'(b1_d_ff) * (2*F+2)'(b1_mul_ff[c]);
         end
      end
      if (o_ready && b2_valid_ff) begin
         out_rgb_ff <= rgb_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_rgb   = out_rgb_ff;

endmodule

`default_nettype wire

/* src/hsl_to_rgb_converter_top.sv */
// HSL to RGB color converter.
// req channel: one beat per color; tdata holds hue (FRAC_BITS bits, fraction of
//   a turn), saturation and lightness (FRAC_BITS+1 bits each, 1.0 = 2^FRAC_BITS).
// rsp channel: one beat per request beat, in order; tdata holds red, green and
//   blue (FRAC_BITS+1 bits each, same scale).
// path: from the accepting edge to rsp_tvalid a beat passes 2 front stages
//   (clamp and l*s product, then q/p and phases), 1 queue slot and
//   3 back stages (segment select, ramp product, output register).
// throughput: one beat per cycle while rsp_tready is high, with the three ramp
//   multipliers running side by side in the back stages.
// reset (synchronous, active high) empties all stages and the 4-entry queue;
//   rsp_tvalid is low in the cycle after reset.
// when rsp_tready is low the back stages hold, the queue fills and the front
//   keeps taking beats until the queue and both front stages are full; then
//   req_tready goes low. A waiting rsp beat holds its data until taken.
`default_nettype none

module hsl_to_rgb_converter_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // hue, saturation, lightness
   input  logic [((3*FRAC_BITS+2+7)/8)*8-1:0]      req_tdata,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // red, green, blue
   output logic [((3*FRAC_BITS+3+7)/8)*8-1:0]      rsp_tdata
);

   localparam int F     = FRAC_BITS;
   localparam int RSP_W = ((3*FRAC_BITS+3+7)/8)*8;
   localparam int QW    = 5*FRAC_BITS+2;

   hsl2rgb_pkg::queue_status_type queue_status;
   logic                          push, pop;
   logic [QW-1:0]                 push_data, head_data;
   logic [2:0][F:0]               rgb;

   hsl2rgb_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_hue       (req_tdata[F-1:0]),
      .in_saturation(req_tdata[2*F:F]),
      .in_lightness (req_tdata[3*F+1:2*F+1]),
      .queue_status (queue_status),
      .push         (push),
      .push_data    (push_data)
   );

   hsl2rgb_queue #(.WIDTH(QW)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .head_data(head_data),
      .status   (queue_status)
   );

   hsl2rgb_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_status(queue_status),
      .head_data   (head_data),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_rgb     (rgb)
   );

   assign rsp_tdata = RSP_W'({rgb[2], rgb[1], rgb[0]});

endmodule

`default_nettype wire

/* src/hsl2rgb_checker.sv */
`default_nettype none

`include "hsl_to_rgb_converter_top_assert.svh"

module hsl2rgb_checker #(
   parameter int FRAC_BITS = 16
) (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [((3*FRAC_BITS+3+7)/8)*8-1:0]  rsp_tdata
);

   localparam int F = FRAC_BITS;
   localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

   `HSL_ASSERT_NEXT(a_rsp_valid_holds, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `HSL_ASSERT_NEXT(a_rsp_data_holds, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `HSL_ASSERT_IMPL(a_no_rsp_after_reset, $past(reset), !rsp_tvalid)
   `HSL_ASSERT_IMPL(a_channels_in_range, rsp_tvalid, (rsp_tdata[F:0] <= ONE) && (rsp_tdata[2*F+1:F+1] <= ONE) && (rsp_tdata[3*F+2:2*F+2] <= ONE))

endmodule

bind hsl_to_rgb_converter_top hsl2rgb_checker #(.FRAC_BITS(FRAC_BITS)) u_hsl2rgb_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

`default_nettype wire

/* tb/hsl_rgb_checker.sv */
module hsl_rgb_checker #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   input  logic                                    req_tready,
   // hue, saturation, lightness
   input  logic [((3*FRAC_BITS+2+7)/8)*8-1:0]      req_tdata,
   input  logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // red, green, blue
   input  logic [((3*FRAC_BITS+3+7)/8)*8-1:0]      rsp_tdata,
   output int                                      failures,
   output int                                      outstanding,
   output int                                      colors_checked
);

   localparam int RSP_W = ((3*FRAC_BITS+3+7)/8)*8;
   localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;
   localparam logic [63:0] THIRD = ONE / 3;
   localparam logic [63:0] HUE_MASK = ONE - 1;

   typedef struct packed {
      logic [FRAC_BITS:0] red;
      logic [FRAC_BITS:0] green;
      logic [FRAC_BITS:0] blue;
   } rgb_type;

   rgb_type expected_colors[$];
   rgb_type want;
   rgb_type got;
   rgb_type fresh;

   initial begin
      failures = 0;
      outstanding = 0;
      colors_checked = 0;
   end

   function automatic logic [63:0] ramp_level(input logic [63:0] t, input logic [63:0] p,
                                              input logic [63:0] q);
      logic [63:0] d;
      d = q - p;
      if (6 * t < ONE) begin
         return p + ((d * 6 * t) >> FRAC_BITS);
      end
      if (2 * t < ONE) begin
         return q;
      end
      if (3 * t < 2 * ONE) begin
         return p + ((d * (4 * ONE - 6 * t)) >> FRAC_BITS);
      end
      return p;
   endfunction

   function automatic rgb_type hsl_color(input logic [FRAC_BITS-1:0] hue_in,
                                         input logic [FRAC_BITS:0] sat_in,
                                         input logic [FRAC_BITS:0] lit_in);
      logic [63:0] hue;
      logic [63:0] s;
      logic [63:0] l;
      logic [63:0] ls;
      logic [63:0] q;
      logic [63:0] p;
      logic [63:0] lvl_red;
      logic [63:0] lvl_green;
      logic [63:0] lvl_blue;
      rgb_type c;
      hue = 64'(hue_in);
      s = (64'(sat_in) > ONE) ? ONE : 64'(sat_in);
      l = (64'(lit_in) > ONE) ? ONE : 64'(lit_in);
      if (s == 0) begin
         c.red = l[FRAC_BITS:0];
         c.green = l[FRAC_BITS:0];
         c.blue = l[FRAC_BITS:0];
         return c;
      end
      ls = (l * s) >> FRAC_BITS;
      if (2 * l < ONE) begin
         q = l + ls;
      end else begin
         q = l + s - ls;
      end
      if (q > ONE) begin
         q = ONE;
      end
      p = (2 * l >= q) ? 2 * l - q : 64'd0;
      if (p > q) begin
         p = q;
      end
      lvl_red = ramp_level((hue + THIRD) & HUE_MASK, p, q);
      lvl_green = ramp_level(hue, p, q);
      lvl_blue = ramp_level((hue + ONE - THIRD) & HUE_MASK, p, q);
      c.red = lvl_red[FRAC_BITS:0];
      c.green = lvl_green[FRAC_BITS:0];
      c.blue = lvl_blue[FRAC_BITS:0];
      return c;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] exp_val,
                                  input logic [63:0] got_val);
      $display("mismatch on rsp beat %0d, %s: expected %0d, got %0d", colors_checked, what,
               exp_val, got_val);
      failures++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.red = rsp_tdata[FRAC_BITS:0];
            got.green = rsp_tdata[2*FRAC_BITS+1:FRAC_BITS+1];
            got.blue = rsp_tdata[3*FRAC_BITS+2:2*FRAC_BITS+2];
            if (expected_colors.size() == 0) begin
               report_mismatch("beat with no color pending", 64'd0, 64'(got));
            end else begin
               want = expected_colors.pop_front();
               if (got.red !== want.red) begin
                  report_mismatch("red", 64'(want.red), 64'(got.red));
               end
               if (got.green !== want.green) begin
                  report_mismatch("green", 64'(want.green), 64'(got.green));
               end
               if (got.blue !== want.blue) begin
                  report_mismatch("blue", 64'(want.blue), 64'(got.blue));
               end
               if (rsp_tdata[RSP_W-1:3*FRAC_BITS+3] !== '0) begin
                  report_mismatch("padding", 64'd0, 64'(rsp_tdata[RSP_W-1:3*FRAC_BITS+3]));
               end
            end
            colors_checked++;
         end
         if (req_tvalid && req_tready) begin
            fresh = hsl_color(req_tdata[FRAC_BITS-1:0],
                              req_tdata[2*FRAC_BITS:FRAC_BITS],
                              req_tdata[3*FRAC_BITS+1:2*FRAC_BITS+1]);
            expected_colors = {expected_colors, fresh};
         end
         outstanding <= expected_colors.size();
      end
   end

endmodule

/* tb/tb_top.sv */
module tb_top;

   localparam int FB = 16;
   localparam int REQ_W = ((3*FB+2+7)/8)*8;
   localparam int RSP_W = ((3*FB+3+7)/8)*8;
   localparam int ONE = 1 << FB;
   localparam int THIRD = ONE / 3;
   localparam int RANDOM_COLORS = 630;

   typedef enum {
      RX_FREE,
      RX_COIN,
      RX_MOSTLY,
      RX_PERIODIC,
      RX_HOLD
   } rx_mode_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   int failures;
   int outstanding;
   int colors_checked;
   int colors_sent = 0;
   int burst_left = 8;
   int hold_cycles = 0;

   hsl_to_rgb_converter_top #(.FRAC_BITS(FB)) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   hsl_rgb_checker #(.FRAC_BITS(FB)) color_check (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .failures(failures),
      .outstanding(outstanding),
      .colors_checked(colors_checked)
   );

   initial begin
      forever begin
         #1 clock = ~clock;
      end
   end

   initial begin
      #400000;
      $display("Verification failed");
      $finish;
   end

   task automatic send_color(input int hue, input int sat, input int lit);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= REQ_W'({(FB+1)'(lit), (FB+1)'(sat), FB'(hue)});
      do begin
         @(posedge clock);
      end while (!req_tready);
      colors_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   function automatic int rand_level();
      int v;
      case ($urandom_range(0, 7))
         0: v = 0;
         1: v = ONE;
         2: v = ONE / 2 - 1 + int'($urandom_range(0, 2));
         default: v = int'($urandom_range(0, ONE));
      endcase
      return v;
   endfunction

   function automatic int rand_hue();
      int corner;
      if ($urandom_range(0, 3) != 0) begin
         return int'($urandom_range(0, ONE - 1));
      end
      case ($urandom_range(0, 5))
         0: corner = ONE / 6;
         1: corner = ONE / 2;
         2: corner = (2 * ONE) / 3;
         3: corner = THIRD;
         4: corner = ONE - THIRD;
         default: corner = 0;
      endcase
      return corner + int'($urandom_range(0, 4)) - 2;
   endfunction

   // receiver: changing stall patterns, with one long hold early on
   initial begin
      rx_mode_type mode;
      int seg_len;
      int seg;
      seg = 0;
      do begin
         @(posedge clock);
      end while (reset);
      forever begin
         seg++;
         if (seg == 3) begin
            mode = RX_HOLD;
            seg_len = 90;
         end else begin
            mode = rx_mode_type'($urandom_range(0, 3));
            seg_len = $urandom_range(20, 120);
         end
         for (int i = 0; i < seg_len; i++) begin
            case (mode)
               RX_FREE: rsp_tready <= 1'b1;
               RX_COIN: rsp_tready <= 1'($urandom_range(0, 1));
               RX_MOSTLY: rsp_tready <= ($urandom_range(0, 3) != 0);
               RX_PERIODIC: rsp_tready <= ((i % 5) < 3);
               RX_HOLD: begin
                  rsp_tready <= 1'b0;
                  hold_cycles++;
               end
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin
      int hue;
      int sat;
      int lit;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_color(0, 0, 0);
      send_color(ONE - 1, ONE, ONE);
      send_color('h1234, 0, ONE / 2);
      send_color(0, 0, ONE);
      send_color(0, ONE, ONE / 2);
      send_color(10922, ONE, ONE / 2);
      send_color(10923, ONE, ONE / 2);
      send_color(32767, ONE, ONE / 2);
      send_color(32768, ONE, ONE / 2);
      send_color(43690, ONE, ONE / 2);
      send_color(43691, ONE, ONE / 2);
      send_color(65535, ONE, ONE / 2);
      send_color(THIRD, ONE, ONE / 2);
      send_color(THIRD - 1, ONE, ONE / 2);
      send_color(5000, 40000, 20000);
      send_color(5000, 40000, 50000);
      send_color(30000, 2 * ONE - 1, ONE / 2);
      send_color(30000, 50000, 2 * ONE - 1);
      send_color(30000, ONE + 1, ONE + 1);
      send_color(50000, 0, 2 * ONE - 1);
      send_color(12345, 1, ONE / 2 - 1);

      for (int n = 0; n < RANDOM_COLORS; n++) begin
         hue = rand_hue();
         case ($urandom_range(0, 9))
            0: begin
               sat = 0;
               lit = rand_level();
            end
            1: begin
               sat = int'($urandom_range(0, 2 * ONE - 1));
               lit = int'($urandom_range(0, 2 * ONE - 1));
            end
            2: begin
               sat = rand_level();
               lit = rand_level();
            end
            default: begin
               sat = int'($urandom_range(0, ONE));
               lit = int'($urandom_range(0, ONE));
            end
         endcase
         send_color(hue, sat, lit);
      end
      req_tvalid <= 1'b0;

      do begin
         @(posedge clock);
      end while (outstanding != 0);
      repeat (12) @(posedge clock);

      $display("%0d colors sent, %0d results checked", colors_sent, colors_checked);
      $display("covered grey, clamped levels, ramp corners and a %0d-cycle output hold",
               hold_cycles);
      if (failures == 0 && outstanding == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+src
src/hsl2rgb_pkg.sv
src/hsl2rgb_front.sv
src/hsl2rgb_queue.sv
src/hsl2rgb_back.sv
src/hsl_to_rgb_converter_top.sv
src/hsl2rgb_checker.sv
tb/hsl_rgb_checker.sv
tb/tb_top.sv
